### sv/button_qualifier_blink_feedback_core_assert.svh
// Assertion macros used by the button qualifier top level.
`ifndef BUTTON_QUALIFIER_BLINK_FEEDBACK_CORE_ASSERT_SVH
`define BUTTON_QUALIFIER_BLINK_FEEDBACK_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BQBF_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqbf assertion failed");

// Next-cycle implication, checked outside reset.
`define BQBF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqbf assertion failed");

`endif

### sv/bqbf_pkg.sv
// Shared types and constants for the button qualifier with blink feedback.
package bqbf_pkg;

    // Configuration register widths
    localparam int DEBOUNCE_W = 10;
    localparam int HALF_W     = 10;
    localparam int GAP_W      = 13;
    localparam int USB_TO_W   = 14;
    localparam int RETRY_W    = 20;
    localparam int HOLDOFF_W  = 16;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    // Odd multiples of the blink half period, up to five times it
    localparam int MULT_W     = 13;
    // Widest configuration value that is compared against a time difference
    localparam int CFG_CMP_W  = 20;

    // Reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd30;
    localparam logic [HALF_W-1:0]     HALF_RST     = 10'd150;
    localparam logic [GAP_W-1:0]      GAP_RST      = 13'd500;
    localparam logic [USB_TO_W-1:0]   USB_TO_RST   = 14'd2000;
    localparam logic [RETRY_W-1:0]    RETRY_RST    = 20'd60000;
    localparam logic [HOLDOFF_W-1:0]  HOLDOFF_RST  = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 3'd0,
        REG_HALF     = 3'd1,
        REG_GAP      = 3'd2,
        REG_USB_TO   = 3'd3,
        REG_RETRY    = 3'd4,
        REG_HOLDOFF  = 3'd5
    } t_reg_idx;

    // Feedback codes
    localparam logic [1:0] CODE_NONE      = 2'd0;
    localparam logic [1:0] CODE_PHOTO     = 2'd1;
    localparam logic [1:0] CODE_UPLOAD_OK = 2'd2;
    localparam logic [1:0] CODE_FAILURE   = 2'd3;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [HALF_W-1:0]     blink_half_ms;
        logic [MULT_W-1:0]     half_x3;
        logic [MULT_W-1:0]     half_x5;
        logic [GAP_W-1:0]      dark_gap_ms;
        logic [USB_TO_W-1:0]   usb_timeout_ms;
        logic [RETRY_W-1:0]    retry_interval_ms;
        logic [HOLDOFF_W-1:0]  sleep_holdoff_ms;
    } t_cfg;

    typedef struct packed {
        logic led_on;
        logic start_photo;
        logic start_upload;
        logic sleep_request;
        logic usb_present;
        logic button_stable;
        logic post_accepted;
        logic feedback_idle;
    } t_result;

endpackage

### sv/button_qualifier_blink_feedback_core.sv
// Top level of the button qualifier with LED blink feedback.
//
//   channel  | handshake            | contents
//   ---------+----------------------+--------------------------------------------
//   tick in  | i_valid / o_ready    | now_ms, button_raw, work_busy, usb_frame,
//            |                      | post_code, work_done
//   result   | o_valid / i_ready    | led_on, start_photo, start_upload,
//            |                      | sleep_request, usb_present, button_stable,
//            |                      | post_accepted, feedback_idle
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_data, no read-back
//
// One item per cycle sustained while i_ready stays high. An item is latched
// in the input register, evaluated in one pass of combinational logic against
// the block state and moved to the result register, which drives o_valid.
// Reset is synchronous, active low, and restores state and the register
// defaults. A stalled result holds the result register; the input register
// still takes one more item, after which o_ready drops.
`include "button_qualifier_blink_feedback_core_assert.svh"

module button_qualifier_blink_feedback_core
    import bqbf_pkg::*;
#(
    parameter int TIME_WIDTH  = 32,
    parameter int FRAME_WIDTH = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // tick in
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [TIME_WIDTH-1:0]  i_now_ms,
    input  logic                   i_button_raw,
    input  logic                   i_work_busy,
    input  logic [FRAME_WIDTH-1:0] i_usb_frame,
    input  logic [1:0]             i_post_code,
    input  logic                   i_work_done,
    // result out
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_led_on,
    output logic                   o_start_photo,
    output logic                   o_start_upload,
    output logic                   o_sleep_request,
    output logic                   o_usb_present,
    output logic                   o_button_stable,
    output logic                   o_post_accepted,
    output logic                   o_feedback_idle
);

    t_cfg    w_cfg;
    t_result w_res;
    t_result r_res;
    logic    w_adv;
    logic    w_accept;

    // input register
    logic                   r_in_vld;
    logic [TIME_WIDTH-1:0]  r_now_ms;
    logic                   r_button_raw;
    logic                   r_work_busy;
    logic [FRAME_WIDTH-1:0] r_usb_frame;
    logic [1:0]             r_post_code;
    logic                   r_work_done;
    logic                   r_out_vld;

    bqbf_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bqbf_tick #(
        .TIME_WIDTH  (TIME_WIDTH),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_tick (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_cfg        (w_cfg),
        .i_now_ms     (r_now_ms),
        .i_button_raw (r_button_raw),
        .i_work_busy  (r_work_busy),
        .i_usb_frame  (r_usb_frame),
        .i_post_code  (r_post_code),
        .i_work_done  (r_work_done),
        .o_result     (w_res)
    );

    // advance the held item whenever the result register is free or draining
    assign w_adv    = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready  = !r_in_vld || w_adv;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    // payload carries no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now_ms     <= i_now_ms;
            r_button_raw <= i_button_raw;
            r_work_busy  <= i_work_busy;
            r_usb_frame  <= i_usb_frame;
            r_post_code  <= i_post_code;
            r_work_done  <= i_work_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_led_on        = r_res.led_on;
    assign o_start_photo   = r_res.start_photo;
    assign o_start_upload  = r_res.start_upload;
    assign o_sleep_request = r_res.sleep_request;
    assign o_usb_present   = r_res.usb_present;
    assign o_button_stable = r_res.button_stable;
    assign o_post_accepted = r_res.post_accepted;
    assign o_feedback_idle = r_res.feedback_idle;

    // upload needs usb present, sleep needs it absent
    `BQBF_ASSERT_NOW(a_upload_sleep_excl, i_clk, i_rst_n, o_valid, !(o_start_upload && o_sleep_request))
    // a lit LED means a code is playing
    `BQBF_ASSERT_NOW(a_led_not_idle, i_clk, i_rst_n, o_valid && o_led_on, !o_feedback_idle)
    // a photo trigger always leaves its code pending
    `BQBF_ASSERT_NOW(a_photo_not_idle, i_clk, i_rst_n, o_valid && o_start_photo, !o_feedback_idle)
    // a held item that cannot advance stays held
    `BQBF_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_vld && !w_adv, r_in_vld)

endmodule

### sv/bqbf_cfg.sv
// Configuration register file with precomputed blink period multiples.
module bqbf_cfg
    import bqbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    logic [MULT_W-1:0] w_half;

    assign w_half = MULT_W'(i_cfg_data[HALF_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms       <= DEBOUNCE_RST;
            r_cfg.blink_half_ms     <= HALF_RST;
            r_cfg.half_x3           <= MULT_W'(HALF_RST) * MULT_W'(3);
            r_cfg.half_x5           <= MULT_W'(HALF_RST) * MULT_W'(5);
            r_cfg.dark_gap_ms       <= GAP_RST;
            r_cfg.usb_timeout_ms    <= USB_TO_RST;
            r_cfg.retry_interval_ms <= RETRY_RST;
            r_cfg.sleep_holdoff_ms  <= HOLDOFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ms <= i_cfg_data[DEBOUNCE_W-1:0];
                REG_HALF: begin
                    // keep the odd multiples next to the half period
                    r_cfg.blink_half_ms <= i_cfg_data[HALF_W-1:0];
                    r_cfg.half_x3       <= w_half + (w_half << 1);
                    r_cfg.half_x5       <= w_half + (w_half << 2);
                end
                REG_GAP:     r_cfg.dark_gap_ms       <= i_cfg_data[GAP_W-1:0];
                REG_USB_TO:  r_cfg.usb_timeout_ms    <= i_cfg_data[USB_TO_W-1:0];
                REG_RETRY:   r_cfg.retry_interval_ms <= i_cfg_data[RETRY_W-1:0];
                REG_HOLDOFF: r_cfg.sleep_holdoff_ms  <= i_cfg_data[HOLDOFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/bqbf_tick.sv
// Per-tick decision logic and the block state it updates.
module bqbf_tick
    import bqbf_pkg::*;
#(
    parameter int TIME_WIDTH  = 32,
    parameter int FRAME_WIDTH = 11
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  t_cfg                   i_cfg,
    input  logic [TIME_WIDTH-1:0]  i_now_ms,
    input  logic                   i_button_raw,
    input  logic                   i_work_busy,
    input  logic [FRAME_WIDTH-1:0] i_usb_frame,
    input  logic [1:0]             i_post_code,
    input  logic                   i_work_done,
    output t_result                o_result
);

    localparam int CMP_W = (TIME_WIDTH > CFG_CMP_W) ? TIME_WIDTH : CFG_CMP_W;

    logic [FRAME_WIDTH-1:0] r_last_frame,  n_last_frame;
    logic [TIME_WIDTH-1:0]  r_last_usb,    n_last_usb;
    logic [1:0]             r_pending,     n_pending;
    logic [1:0]             r_playing,     n_playing;
    logic [TIME_WIDTH-1:0]  r_play_start,  n_play_start;
    logic [TIME_WIDTH-1:0]  r_dark_since,  n_dark_since;
    logic                   r_prev_level,  n_prev_level;
    logic                   r_stable,      n_stable;
    logic                   r_armed,       n_armed;
    logic [TIME_WIDTH-1:0]  r_level_time,  n_level_time;
    logic [TIME_WIDTH-1:0]  r_attempt,     n_attempt;

    logic [CMP_W-1:0] w_el;
    logic [CMP_W-1:0] w_h1, w_h2, w_h3, w_h4, w_h5, w_h6, w_total;
    logic             w_in_phase;
    t_result          w_res;

    // blink period multiples widened to the compare width
    assign w_h1 = CMP_W'(i_cfg.blink_half_ms);
    assign w_h2 = w_h1 << 1;
    assign w_h3 = CMP_W'(i_cfg.half_x3);
    assign w_h4 = w_h1 << 2;
    assign w_h5 = CMP_W'(i_cfg.half_x5);
    assign w_h6 = w_h3 << 1;

    always_comb begin
        n_last_frame = r_last_frame;
        n_last_usb   = r_last_usb;
        n_pending    = r_pending;
        n_playing    = r_playing;
        n_play_start = r_play_start;
        n_dark_since = r_dark_since;
        n_prev_level = r_prev_level;
        n_stable     = r_stable;
        n_armed      = r_armed;
        n_level_time = r_level_time;
        n_attempt    = r_attempt;
        w_res        = '0;
        w_el         = '0;
        w_total      = '0;
        w_in_phase   = 1'b0;

        // worker side
        if (i_work_done) begin
            n_attempt = i_now_ms;
        end
        if (i_post_code != CODE_NONE && r_pending == CODE_NONE) begin
            n_pending           = i_post_code;
            w_res.post_accepted = 1'b1;
        end

        // usb activity
        if (i_usb_frame != r_last_frame) begin
            n_last_usb   = i_now_ms;
            n_last_frame = i_usb_frame;
        end

        // feedback playback
        if (r_playing == CODE_NONE && n_pending != CODE_NONE &&
            CMP_W'(TIME_WIDTH'(i_now_ms - r_dark_since)) >= CMP_W'(i_cfg.dark_gap_ms)) begin
            n_playing    = n_pending;
            n_play_start = i_now_ms;
        end
        if (n_playing != CODE_NONE) begin
            w_el = CMP_W'(TIME_WIDTH'(i_now_ms - n_play_start));
            // LED is lit in even half periods, never in the final dark half
            unique case (n_playing)
                CODE_PHOTO: begin
                    w_total    = w_h2;
                    w_in_phase = (w_el < w_h1);
                end
                CODE_UPLOAD_OK: begin
                    w_total    = w_h4;
                    w_in_phase = (w_el < w_h1) || (w_el >= w_h2 && w_el < w_h3);
                end
                default: begin
                    w_total    = w_h6;
                    w_in_phase = (w_el < w_h1) || (w_el >= w_h2 && w_el < w_h3) ||
                                 (w_el >= w_h4 && w_el < w_h5);
                end
            endcase
            w_res.led_on = w_in_phase;
            if (w_el >= w_total) begin
                w_res.led_on = 1'b0;
                if (n_pending == n_playing) begin
                    n_pending = CODE_NONE;
                end
                n_playing    = CODE_NONE;
                n_dark_since = i_now_ms;
            end
        end

        // debounce and release trigger
        if (i_button_raw != r_prev_level) begin
            n_prev_level = i_button_raw;
            n_level_time = i_now_ms;
        end
        if (CMP_W'(TIME_WIDTH'(i_now_ms - n_level_time)) >= CMP_W'(i_cfg.debounce_ms) &&
            r_stable != i_button_raw) begin
            n_stable = i_button_raw;
            if (i_button_raw) begin
                n_armed = 1'b1;
            end else begin
                if (r_armed && !i_work_busy && n_pending == CODE_NONE &&
                    n_playing == CODE_NONE) begin
                    n_pending         = CODE_PHOTO;
                    w_res.start_photo = 1'b1;
                end
                n_armed = 1'b0;
            end
        end

        w_res.usb_present = CMP_W'(TIME_WIDTH'(i_now_ms - n_last_usb)) <
                            CMP_W'(i_cfg.usb_timeout_ms);

        // idle checks
        if (!i_work_busy && n_pending == CODE_NONE && n_playing == CODE_NONE && n_stable) begin
            w_res.sleep_request = !w_res.usb_present &&
                                  (CMP_W'(i_now_ms) > CMP_W'(i_cfg.sleep_holdoff_ms));
            w_res.start_upload  = w_res.usb_present &&
                                  (CMP_W'(TIME_WIDTH'(i_now_ms - n_attempt)) >
                                   CMP_W'(i_cfg.retry_interval_ms));
        end

        w_res.button_stable = n_stable;
        w_res.feedback_idle = (n_pending == CODE_NONE) && (n_playing == CODE_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_frame <= '0;
            r_last_usb   <= '0;
            r_pending    <= CODE_NONE;
            r_playing    <= CODE_NONE;
            r_play_start <= '0;
            r_dark_since <= '0;
            r_prev_level <= 1'b0;
            r_stable     <= 1'b0;
            r_armed      <= 1'b0;
            r_level_time <= '0;
            r_attempt    <= '0;
        end else if (i_adv) begin
            r_last_frame <= n_last_frame;
            r_last_usb   <= n_last_usb;
            r_pending    <= n_pending;
            r_playing    <= n_playing;
            r_play_start <= n_play_start;
            r_dark_since <= n_dark_since;
            r_prev_level <= n_prev_level;
            r_stable     <= n_stable;
            r_armed      <= n_armed;
            r_level_time <= n_level_time;
            r_attempt    <= n_attempt;
        end
    end

    assign o_result = w_res;

endmodule

### tb/tb.sv
// Testbench for the button qualifier with LED blink feedback core.
`timescale 1ns / 100ps

module tb;
    import bqbf_pkg::*;

    localparam int TW          = 32;
    localparam int FW          = 11;
    localparam int QUIET_LIMIT = 2000;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [TW-1:0] now_ms;
        logic          button_raw;
        logic          work_busy;
        logic [FW-1:0] usb_frame;
        logic [1:0]    post_code;
        logic          work_done;
    } t_tick;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  i_ready    = 1'b0;
    t_tick                 tick_bus   = '0;
    logic o_ready, o_valid;
    logic o_led_on, o_start_photo, o_start_upload, o_sleep_request;
    logic o_usb_present, o_button_stable, o_post_accepted, o_feedback_idle;

    t_tick   pending_ticks[$];
    t_result predicted_results[$];
    int      fail_count   = 0;
    int      gap_left     = 0;
    int      stall_left   = 0;
    int      quiet_cycles = 0;
    bit      idling_on    = 1'b1;

    // Result fields, MSB of t_result first
    string result_field[8] = '{"led_on", "start_photo", "start_upload", "sleep_request",
                               "usb_present", "button_stable", "post_accepted",
                               "feedback_idle"};

    // Register copies held by the predictor
    logic [DEBOUNCE_W-1:0] c_deb     = DEBOUNCE_RST;
    logic [HALF_W-1:0]     c_half    = HALF_RST;
    logic [GAP_W-1:0]      c_gap     = GAP_RST;
    logic [USB_TO_W-1:0]   c_usb_to  = USB_TO_RST;
    logic [RETRY_W-1:0]    c_retry   = RETRY_RST;
    logic [HOLDOFF_W-1:0]  c_holdoff = HOLDOFF_RST;

    // Block state as the predictor sees it
    logic [FW-1:0] p_frame     = '0;
    logic [TW-1:0] p_usb_t     = '0;
    logic [1:0]    p_pend      = CODE_NONE;
    logic [1:0]    p_play      = CODE_NONE;
    logic [TW-1:0] p_play_t    = '0;
    logic [TW-1:0] p_dark_t    = '0;
    logic          p_prev_lvl  = 1'b0;
    logic          p_stab_lvl  = 1'b0;
    logic          p_armed     = 1'b0;
    logic [TW-1:0] p_chg_t     = '0;
    logic [TW-1:0] p_attempt_t = '0;

    // Stimulus generator state
    logic [TW-1:0] gen_now    = '0;
    logic          gen_btn    = 1'b0;
    logic          gen_busy   = 1'b0;
    logic          gen_usb_on = 1'b1;
    logic [FW-1:0] gen_frame  = '0;

    button_qualifier_blink_feedback_core #(
        .TIME_WIDTH (TW),
        .FRAME_WIDTH(FW)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_now_ms       (tick_bus.now_ms),
        .i_button_raw   (tick_bus.button_raw),
        .i_work_busy    (tick_bus.work_busy),
        .i_usb_frame    (tick_bus.usb_frame),
        .i_post_code    (tick_bus.post_code),
        .i_work_done    (tick_bus.work_done),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_led_on       (o_led_on),
        .o_start_photo  (o_start_photo),
        .o_start_upload (o_start_upload),
        .o_sleep_request(o_sleep_request),
        .o_usb_present  (o_usb_present),
        .o_button_stable(o_button_stable),
        .o_post_accepted(o_post_accepted),
        .o_feedback_idle(o_feedback_idle)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the predicted block state by one tick and return its result.
    // Order: worker inputs, USB presence, playback, debounce, idle checks.
    function automatic t_result qualify_tick(input t_tick tk);
        t_result       r;
        logic [TW-1:0] el;
        logic [TW-1:0] since;
        logic [63:0]   total;
        logic [63:0]   half_idx;
        r = '0;

        if (tk.work_done)
            p_attempt_t = tk.now_ms;
        if (tk.post_code != CODE_NONE && p_pend == CODE_NONE) begin
            p_pend = tk.post_code;
            r.post_accepted = 1'b1;
        end

        if (tk.usb_frame != p_frame) begin
            p_usb_t = tk.now_ms;
            p_frame = tk.usb_frame;
        end

        // Start a pending code only once the dark gap has run out
        since = tk.now_ms - p_dark_t;
        if (p_play == CODE_NONE && p_pend != CODE_NONE && since >= c_gap) begin
            p_play   = p_pend;
            p_play_t = tk.now_ms;
        end
        if (p_play != CODE_NONE) begin
            el       = tk.now_ms - p_play_t;
            total    = 64'(p_play) * 64'd2 * 64'(c_half);
            half_idx = (c_half != '0) ? 64'(el) / 64'(c_half) : 64'd1;
            r.led_on = !half_idx[0] && (64'(el) + 64'(c_half) < total);
            if (64'(el) >= total) begin
                r.led_on = 1'b0;
                // Drop the pending code only if it is the one just played
                if (p_pend == p_play)
                    p_pend = CODE_NONE;
                p_play   = CODE_NONE;
                p_dark_t = tk.now_ms;
            end
        end

        if (tk.button_raw != p_prev_lvl) begin
            p_prev_lvl = tk.button_raw;
            p_chg_t    = tk.now_ms;
        end
        since = tk.now_ms - p_chg_t;
        if (since >= c_deb && p_stab_lvl != tk.button_raw) begin
            p_stab_lvl = tk.button_raw;
            if (p_stab_lvl) begin
                p_armed = 1'b1;
            end else begin
                // Qualified release: armed by a stable high, block idle
                if (p_armed && !tk.work_busy && p_pend == CODE_NONE && p_play == CODE_NONE) begin
                    p_pend        = CODE_PHOTO;
                    r.start_photo = 1'b1;
                end
                p_armed = 1'b0;
            end
        end

        since         = tk.now_ms - p_usb_t;
        r.usb_present = since < c_usb_to;

        if (!tk.work_busy && p_pend == CODE_NONE && p_play == CODE_NONE && p_stab_lvl) begin
            // Hold-off compares the absolute timestamp
            if (!r.usb_present && tk.now_ms > c_holdoff)
                r.sleep_request = 1'b1;
            since = tk.now_ms - p_attempt_t;
            if (r.usb_present && since > c_retry)
                r.start_upload = 1'b1;
        end

        r.button_stable = p_stab_lvl;
        r.feedback_idle = (p_pend == CODE_NONE && p_play == CODE_NONE);
        return r;
    endfunction

    function automatic t_tick mk_tick(input logic [TW-1:0] now, input logic raw,
                                      input logic busy, input logic [FW-1:0] frame,
                                      input logic [1:0] post, input logic done);
        t_tick tk;
        tk.now_ms     = now;
        tk.button_raw = raw;
        tk.work_busy  = busy;
        tk.usb_frame  = frame;
        tk.post_code  = post;
        tk.work_done  = done;
        return tk;
    endfunction

    // Mostly short steps against the phase scale, some long, a few wild jumps
    function automatic logic [TW-1:0] next_step(input int unsigned fine);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, fine);
        else if (pick < 90)
            return $urandom_range(0, fine * 8);
        else if (pick < 98)
            return $urandom_range(0, fine * 64);
        else
            return $urandom();
    endfunction

    // Queue random ticks: held button levels with glitches, busy runs ending
    // in a done pulse, USB on/off stretches, occasional posted codes.
    task automatic add_random(input int n, input int unsigned fine);
        logic       raw;
        logic       done;
        logic [1:0] post;
        for (int k = 0; k < n; k++) begin
            gen_now = gen_now + next_step(fine);
            if ($urandom_range(0, 9) == 0)
                gen_btn = !gen_btn;
            raw = gen_btn;
            if ($urandom_range(0, 29) == 0)
                raw = !gen_btn;
            done = 1'b0;
            if (gen_busy && $urandom_range(0, 7) == 0) begin
                gen_busy = 1'b0;
                done     = 1'b1;
            end else if (!gen_busy && $urandom_range(0, 29) == 0) begin
                gen_busy = 1'b1;
            end
            if ($urandom_range(0, 49) == 0)
                done = 1'b1;
            post = CODE_NONE;
            if (done && $urandom_range(0, 1) == 1)
                post = $urandom_range(0, 1) ? CODE_UPLOAD_OK : CODE_FAILURE;
            else if ($urandom_range(0, 29) == 0)
                post = 2'($urandom_range(CODE_PHOTO, CODE_FAILURE));
            if ($urandom_range(0, 39) == 0)
                gen_usb_on = !gen_usb_on;
            if (gen_usb_on)
                gen_frame = gen_frame + (($urandom_range(0, 7) == 0) ?
                                         FW'($urandom_range(1, 2047)) : FW'(1));
            pending_ticks.push_back(mk_tick(gen_now, raw, gen_busy, gen_frame, post, done));
        end
    endtask

    // Hold until every tick is in and every result is out.
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || i_valid || predicted_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_DEBOUNCE: c_deb     = val[DEBOUNCE_W-1:0];
            REG_HALF:     c_half    = val[HALF_W-1:0];
            REG_GAP:      c_gap     = val[GAP_W-1:0];
            REG_USB_TO:   c_usb_to  = val[USB_TO_W-1:0];
            REG_RETRY:    c_retry   = val[RETRY_W-1:0];
            REG_HOLDOFF:  c_holdoff = val[HOLDOFF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] deb, half, gap, usb_to, retry,
                              hold);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_HALF, half);
        write_reg(REG_GAP, gap);
        write_reg(REG_USB_TO, usb_to);
        write_reg(REG_RETRY, retry);
        write_reg(REG_HOLDOFF, hold);
        @(negedge i_clk);
    endtask

    // Tick driver: predict each accepted item, then present the next one,
    // with random gaps after an item while idling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                predicted_results.push_back(qualify_tick(tick_bus));
            if (!i_valid || o_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    tick_bus <= pending_ticks.pop_front();
                    i_valid  <= 1'b1;
                    if (idling_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 9);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each result with the oldest prediction and
    // stall the result channel in random bursts.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_led_on, o_start_photo, o_start_upload, o_sleep_request,
                       o_usb_present, o_button_stable, o_post_accepted, o_feedback_idle};
                if (predicted_results.size() == 0) begin
                    $error("result item with no tick waiting: %b", got);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    for (int k = 0; k < 8; k++) begin
                        if (got[7-k] !== want[7-k]) begin
                            $error("%s: expected %b, actual %b", result_field[k],
                                   want[7-k], got[7-k]);
                            fail_count++;
                        end
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 9);
            end
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed ticks at reset settings: arm and release, a photo code,
        // rejected and accepted posts, sleep, upload, timestamp wrap.
        pending_ticks.push_back(mk_tick(32'd0, 1'b1, 1'b0, 11'd0, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd40, 1'b1, 1'b0, 11'd0, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd50, 1'b0, 1'b0, 11'd0, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd85, 1'b0, 1'b0, 11'd0, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd90, 1'b0, 1'b0, 11'd2047, CODE_UPLOAD_OK, 1'b0));
        pending_ticks.push_back(mk_tick(32'd600, 1'b0, 1'b0, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd760, 1'b0, 1'b0, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd900, 1'b0, 1'b0, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd901, 1'b0, 1'b0, 11'd2047, CODE_FAILURE, 1'b1));
        pending_ticks.push_back(mk_tick(32'd1401, 1'b0, 1'b0, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd1402, 1'b1, 1'b1, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd2500, 1'b1, 1'b1, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd7000, 1'b1, 1'b0, 11'd2047, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd7001, 1'b1, 1'b0, 11'd0, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd70000, 1'b1, 1'b0, 11'd1, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'hFFFF_FFF0, 1'b1, 1'b0, 11'd1, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 11'd1, CODE_PHOTO, 1'b0));
        pending_ticks.push_back(mk_tick(32'd0, 1'b0, 1'b0, 11'd1365, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'd40, 1'b0, 1'b1, 11'd682, CODE_NONE, 1'b0));
        pending_ticks.push_back(mk_tick(32'h8000_0000, 1'b1, 1'b0, 11'd682, CODE_UPLOAD_OK,
                                        1'b1));
        gen_now   = 32'h8000_0000;
        gen_btn   = 1'b1;
        gen_frame = 11'd682;
        add_random(130, 20);
        wait_idle();

        // Small settings so blinks, gaps and timeouts happen within a few ticks
        set_config(20'd3, 20'd4, 20'd10, 20'd20, 20'd100, 20'd200);
        gen_now = '0;
        add_random(330, 2);
        wait_idle();

        // Upper extremes, timestamps close to the wrap
        set_config(20'd1000, 20'd1000, 20'd5000, 20'd10000, 20'd600000, 20'd60000);
        gen_now = 32'hFFF0_0000;
        add_random(100, 200);
        wait_idle();

        // Lower extremes: no dark gap, no hold-off
        set_config(20'd1, 20'd1, 20'd0, 20'd1, 20'd1, 20'd0);
        gen_now = '0;
        add_random(150, 1);
        wait_idle();

        // Zero blink half period, values wider than their registers, unused index
        set_config(20'hFFC05, 20'h00000, 20'hF0008, 20'hFC00F, 20'hFFFFF, 20'hF0100);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 20'hFFFFF)));
        @(negedge i_clk);
        gen_now = '0;
        add_random(150, 3);
        wait_idle();

        // Random moderate settings
        set_config(CFG_DATA_W'($urandom_range(1, 40)), CFG_DATA_W'($urandom_range(1, 30)),
                   CFG_DATA_W'($urandom_range(0, 200)), CFG_DATA_W'($urandom_range(1, 300)),
                   CFG_DATA_W'($urandom_range(1, 3000)),
                   CFG_DATA_W'($urandom_range(0, 60000)));
        gen_now = 32'hFFFF_F000;
        add_random(200, 5);
        wait_idle();

        // Last stretch: drop all idling on both channels
        set_config(CFG_DATA_W'($urandom_range(1, 20)), CFG_DATA_W'($urandom_range(1, 20)),
                   CFG_DATA_W'($urandom_range(0, 100)), CFG_DATA_W'($urandom_range(1, 200)),
                   CFG_DATA_W'($urandom_range(1, 1000)),
                   CFG_DATA_W'($urandom_range(0, 300)));
        idling_on = 1'b0;
        gen_now   = '0;
        add_random(100, 4);
        wait_idle();

        // Let any stray result show up before closing
        repeat (8) @(posedge i_clk);
        if (predicted_results.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
